// ----- hw/rtl/cht_pkg.sv -----
`timescale 1ns / 1ps

package cht_pkg;

   // command codes on req_command
   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // top level sequencer
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_BKT,
      S_ENT,
      S_CMP,
      S_INS_PAIR,
      S_INS_REC,
      S_INS_LINK,
      S_DONE
   } state_type;

   localparam int POS_W    = 10;
   localparam int VAL_W    = 4;
   localparam int STATUS_W = 4;
   localparam int MOVE_W   = 11;
   localparam int WORD_W   = 64;
   localparam int MULT_W   = 10;
   localparam int STEP_W   = 4;
   localparam int PAIR_W   = POS_W + VAL_W;

   localparam logic [MULT_W-1:0] HASH_MULT_RESET = 10'd31;
   localparam logic [MOVE_W-1:0] MOVE_NONE       = 11'h7FF;

endpackage

// ----- hw/rtl/cht_hash_unit.sv -----
`timescale 1ns / 1ps

// bit-serial modular multiply-add: h = (R*h + x) mod BUCKETS, run twice per pair
module cht_hash_unit #(
   parameter int BUCKETS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cht_pkg::MULT_W-1:0]          mult,
   input  logic [$clog2(BUCKETS)-1:0]          h_in,
   input  logic [cht_pkg::POS_W-1:0]           pos,
   input  logic [cht_pkg::VAL_W-1:0]           val,
   output logic                                done,
   output logic [$clog2(BUCKETS)-1:0]          h_out
);

   localparam int HW = $clog2(BUCKETS);
   localparam logic [HW+1:0] B1 = (HW+2)'(BUCKETS);
   localparam logic [HW+1:0] B2 = (HW+2)'(2 * BUCKETS);
   localparam logic [cht_pkg::STEP_W-1:0] TOP_STEP = cht_pkg::STEP_W'(cht_pkg::MULT_W - 1);

   logic                          run_ff, run_in;
   logic                          phase_ff, phase_in;
   logic [cht_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [HW-1:0]                 acc_ff, acc_in;
   logic [HW-1:0]                 base_ff, base_in;
   logic [cht_pkg::POS_W-1:0]     x_ff, x_in;
   logic [cht_pkg::MULT_W-1:0]    mult_ff, mult_in;
   logic [cht_pkg::VAL_W-1:0]     val_ff, val_in;

   logic [HW+1:0] sum;
   logic [HW+1:0] red;

   always_comb begin
      sum = {1'b0, acc_ff, 1'b0}
          + (mult_ff[step_ff] ? {2'b00, base_ff} : '0)
          + (HW+2)'(x_ff[step_ff]);
      priority if (sum >= B2) begin
         red = sum - B2;
      end else if (sum >= B1) begin
         red = sum - B1;
      end else begin
         red = sum;
      end
   end

   assign h_out = red[HW-1:0];
   assign done  = run_ff && phase_ff && (step_ff == '0);

   always_comb begin
      run_in   = run_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      x_in     = x_ff;
      mult_in  = mult_ff;
      val_in   = val_ff;
      if (start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         step_in  = TOP_STEP;
         acc_in   = '0;
         base_in  = h_in;
         x_in     = pos;
         mult_in  = mult;
         val_in   = val;
      end else if (run_ff) begin
         acc_in = red[HW-1:0];
         if (step_ff == '0) begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               step_in  = TOP_STEP;
               acc_in   = '0;
               base_in  = red[HW-1:0];
               x_in     = cht_pkg::POS_W'(val_ff);
            end else begin
               run_in = 1'b0;
            end
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      phase_ff <= phase_in;
      step_ff  <= step_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      x_ff     <= x_in;
      mult_ff  <= mult_in;
      val_ff   <= val_in;
   end

endmodule

// ----- hw/rtl/chained_hash_table_engine.sv -----
`timescale 1ns / 1ps
// append: two 10-step passes of the serial hash unit; dropped, setting overflow, when the key is full
// clear sweeps every bucket; lookup reads the bucket, then each chain entry visited and each pair compared
// insert: copies each key pair, writes the record, then links the old tail when the bucket already has a chain
// one item at a time, no overlap; a finished word may wait on rsp_ready while the next is taken
// reset: synchronous, then a sweep empties every bucket of the bucket table, req_ready low
module chained_hash_table_engine #(
   parameter int BUCKETS      = 1024,
   parameter int POOL_ENTRIES = 4096,
   parameter int MAX_KEY      = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [cht_pkg::MULT_W-1:0]             csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_command,
   input  logic [cht_pkg::POS_W-1:0]              req_key_pos,
   input  logic [cht_pkg::VAL_W-1:0]              req_key_val,
   input  logic [cht_pkg::STATUS_W-1:0]           req_data_status,
   input  logic signed [cht_pkg::MOVE_W-1:0]      req_data_move,
   input  logic [cht_pkg::WORD_W-1:0]             req_data_loss,
   input  logic [cht_pkg::WORD_W-1:0]             req_data_weight,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic                                   rsp_pool_full,
   output logic                                   rsp_key_too_long,
   output logic [cht_pkg::STATUS_W-1:0]           rsp_found_status,
   output logic signed [cht_pkg::MOVE_W-1:0]      rsp_found_move,
   output logic [cht_pkg::WORD_W-1:0]             rsp_found_loss,
   output logic [cht_pkg::WORD_W-1:0]             rsp_found_weight
);

   localparam int HW     = $clog2(BUCKETS);
   localparam int EW     = $clog2(POOL_ENTRIES);
   localparam int UW     = $clog2(POOL_ENTRIES + 1);
   localparam int LW     = $clog2(MAX_KEY + 1);
   localparam int KW     = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int PAW    = $clog2(POOL_ENTRIES * MAX_KEY);
   localparam int BKT_W  = 1 + 2 * EW;
   localparam int LINK_W = 1 + EW;
   localparam int INFO_W = LW + cht_pkg::STATUS_W + cht_pkg::MOVE_W + 2 * cht_pkg::WORD_W;
   localparam int PW     = cht_pkg::PAIR_W;

   localparam logic [PAW-1:0] MK_P     = PAW'(MAX_KEY);
   localparam logic [LW-1:0]  LEN_MAX  = LW'(MAX_KEY);
   localparam logic [UW-1:0]  USED_MAX = UW'(POOL_ENTRIES);
   localparam logic [HW-1:0]  BKT_LAST = HW'(BUCKETS - 1);

   // ---------------------------------------------------------------- memories
   // bucket table: valid, head, tail
   logic [BKT_W-1:0]  bkt_mem [BUCKETS];
   logic              bkt_re, bkt_we;
   logic [HW-1:0]     bkt_raddr, bkt_waddr;
   logic [BKT_W-1:0]  bkt_wdata, bkt_rd_ff;

   // chain links: has_next, next
   logic [LINK_W-1:0] link_mem [POOL_ENTRIES];
   logic              link_re, link_we;
   logic [EW-1:0]     link_raddr, link_waddr;
   logic [LINK_W-1:0] link_wdata, link_rd_ff;

   // entry record: length, status, move, loss, weight
   logic [INFO_W-1:0] info_mem [POOL_ENTRIES];
   logic              info_re, info_we;
   logic [EW-1:0]     info_raddr, info_waddr;
   logic [INFO_W-1:0] info_wdata, info_rd_ff;

   // stored key pairs, MAX_KEY slots per entry
   logic [PW-1:0]     pair_mem [POOL_ENTRIES * MAX_KEY];
   logic              pair_re, pair_we;
   logic [PAW-1:0]    pair_raddr, pair_waddr;
   logic [PW-1:0]     pair_wdata, pair_rd_ff;

   // pending key being streamed in
   logic [PW-1:0]     pend_mem [MAX_KEY];
   logic              pend_re, pend_we;
   logic [KW-1:0]     pend_raddr, pend_waddr;
   logic [PW-1:0]     pend_wdata, pend_rd_ff;

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_waddr] <= bkt_wdata;
      end
      if (bkt_re) begin
         bkt_rd_ff <= bkt_mem[bkt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_waddr] <= info_wdata;
      end
      if (info_re) begin
         info_rd_ff <= info_mem[info_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_waddr] <= pair_wdata;
      end
      if (pair_re) begin
         pair_rd_ff <= pair_mem[pair_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= pend_wdata;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[pend_raddr];
      end
   end

   // ---------------------------------------------------------------- state
   cht_pkg::state_type              state_ff, state_in;
   cht_pkg::cmd_type                cmd_ff, cmd_in, req_cmd;
   logic [HW-1:0]                   clr_idx_ff, clr_idx_in;
   logic [UW-1:0]                   used_ff, used_in;
   logic [LW-1:0]                   plen_ff, plen_in;
   logic [HW-1:0]                   hash_ff, hash_in;
   logic                            ovf_ff, ovf_in;
   logic [cht_pkg::MULT_W-1:0]      mult_ff;
   logic [EW-1:0]                   cur_ff, cur_in;
   logic [LW-1:0]                   j_ff, j_in;
   logic [cht_pkg::STATUS_W-1:0]    dat_status_ff, dat_status_in;
   logic [cht_pkg::MOVE_W-1:0]      dat_move_ff, dat_move_in;
   logic [cht_pkg::WORD_W-1:0]      dat_loss_ff, dat_loss_in;
   logic [cht_pkg::WORD_W-1:0]      dat_weight_ff, dat_weight_in;
   logic                            res_hit_ff, res_hit_in;
   logic                            res_full_ff, res_full_in;
   logic                            res_long_ff, res_long_in;

   // response register, parts the two sides
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic                            rsp_full_ff, rsp_full_in;
   logic                            rsp_long_ff, rsp_long_in;
   logic [cht_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [cht_pkg::MOVE_W-1:0]      rsp_move_ff, rsp_move_in;
   logic [cht_pkg::WORD_W-1:0]      rsp_loss_ff, rsp_loss_in;
   logic [cht_pkg::WORD_W-1:0]      rsp_weight_ff, rsp_weight_in;

   // hash unit hookup
   logic                            hash_start, hash_done;
   logic [HW-1:0]                   hash_out;

   cht_hash_unit #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .mult   (mult_ff),
      .h_in   (hash_ff),
      .pos    (req_key_pos),
      .val    (req_key_val),
      .done   (hash_done),
      .h_out  (hash_out)
   );

   // fields of read words
   logic                         b_valid;
   logic [EW-1:0]                b_head, b_tail;
   logic                         l_has;
   logic [EW-1:0]                l_next;
   logic [LW-1:0]                i_len;
   logic [cht_pkg::STATUS_W-1:0] i_status;
   logic [cht_pkg::MOVE_W-1:0]   i_move;
   logic [cht_pkg::WORD_W-1:0]   i_loss, i_weight;
   logic [LW-1:0]                j_next;

   assign {b_valid, b_head, b_tail}                 = bkt_rd_ff;
   assign {l_has, l_next}                           = link_rd_ff;
   assign {i_len, i_status, i_move, i_loss, i_weight} = info_rd_ff;
   assign j_next  = j_ff + 1'b1;
   assign req_cmd = cht_pkg::cmd_type'(req_command);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      clr_idx_in    = clr_idx_ff;
      used_in       = used_ff;
      plen_in       = plen_ff;
      hash_in       = hash_ff;
      ovf_in        = ovf_ff;
      cur_in        = cur_ff;
      j_in          = j_ff;
      dat_status_in = dat_status_ff;
      dat_move_in   = dat_move_ff;
      dat_loss_in   = dat_loss_ff;
      dat_weight_in = dat_weight_ff;
      res_hit_in    = res_hit_ff;
      res_full_in   = res_full_ff;
      res_long_in   = res_long_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_status_in = rsp_status_ff;
      rsp_move_in   = rsp_move_ff;
      rsp_loss_in   = rsp_loss_ff;
      rsp_weight_in = rsp_weight_ff;

      req_ready  = 1'b0;
      hash_start = 1'b0;

      bkt_re = 1'b0;  bkt_raddr = hash_ff;  bkt_we = 1'b0;  bkt_waddr = hash_ff;
      bkt_wdata = '0;
      link_re = 1'b0; link_raddr = l_next;  link_we = 1'b0; link_waddr = cur_ff;
      link_wdata = '0;
      info_re = 1'b0; info_raddr = l_next;  info_we = 1'b0; info_waddr = cur_ff;
      info_wdata = {plen_ff, dat_status_ff, dat_move_ff, dat_loss_ff, dat_weight_ff};
      pair_re = 1'b0; pair_raddr = PAW'(cur_ff) * MK_P + PAW'(j_next);
      pair_we = 1'b0; pair_waddr = PAW'(cur_ff) * MK_P + PAW'(j_ff);
      pair_wdata = pend_rd_ff;
      pend_re = 1'b0; pend_raddr = j_next[KW-1:0];
      pend_we = 1'b0; pend_waddr = plen_ff[KW-1:0];
      pend_wdata = {req_key_pos, req_key_val};

      unique case (state_ff)
         cht_pkg::S_CLEAR: begin
            // sweep empties one bucket a cycle
            bkt_we    = 1'b1;
            bkt_waddr = clr_idx_ff;
            bkt_wdata = '0;
            if (clr_idx_ff == BKT_LAST) begin
               state_in = cht_pkg::S_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         cht_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  cht_pkg::CMD_APPEND: begin
                     if (plen_ff == LEN_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        pend_we    = 1'b1;
                        plen_in    = plen_ff + 1'b1;
                        hash_start = 1'b1;
                        state_in   = cht_pkg::S_HASH;
                     end
                  end
                  cht_pkg::CMD_CLEAR: begin
                     used_in    = '0;
                     plen_in    = '0;
                     hash_in    = '0;
                     ovf_in     = 1'b0;
                     clr_idx_in = '0;
                     state_in   = cht_pkg::S_CLEAR;
                  end
                  cht_pkg::CMD_LOOKUP, cht_pkg::CMD_INSERT: begin
                     cmd_in        = req_cmd;
                     dat_status_in = req_data_status;
                     dat_move_in   = req_data_move;
                     dat_loss_in   = req_data_loss;
                     dat_weight_in = req_data_weight;
                     res_hit_in    = 1'b0;
                     res_full_in   = 1'b0;
                     res_long_in   = ovf_ff;
                     if (ovf_ff) begin
                        state_in = cht_pkg::S_DONE;
                     end else begin
                        bkt_re   = 1'b1;
                        state_in = cht_pkg::S_BKT;
                     end
                  end
                  default: begin
                     state_in = cht_pkg::S_IDLE;
                  end
               endcase
            end
         end

         cht_pkg::S_HASH: begin
            if (hash_done) begin
               hash_in  = hash_out;
               state_in = cht_pkg::S_IDLE;
            end
         end

         cht_pkg::S_BKT: begin
            if (cmd_ff == cht_pkg::CMD_LOOKUP) begin
               if (!b_valid) begin
                  state_in = cht_pkg::S_DONE;
               end else begin
                  cur_in     = b_head;
                  link_re    = 1'b1;
                  link_raddr = b_head;
                  info_re    = 1'b1;
                  info_raddr = b_head;
                  state_in   = cht_pkg::S_ENT;
               end
            end else begin
               if (used_ff == USED_MAX) begin
                  res_full_in = 1'b1;
                  state_in    = cht_pkg::S_DONE;
               end else begin
                  cur_in = used_ff[EW-1:0];
                  j_in   = '0;
                  if (plen_ff == '0) begin
                     state_in = cht_pkg::S_INS_REC;
                  end else begin
                     pend_re    = 1'b1;
                     pend_raddr = '0;
                     state_in   = cht_pkg::S_INS_PAIR;
                  end
               end
            end
         end

         cht_pkg::S_ENT: begin
            if (i_len == plen_ff) begin
               if (plen_ff == '0) begin
                  res_hit_in = 1'b1;
                  state_in   = cht_pkg::S_DONE;
               end else begin
                  j_in       = '0;
                  pair_re    = 1'b1;
                  pair_raddr = PAW'(cur_ff) * MK_P;
                  pend_re    = 1'b1;
                  pend_raddr = '0;
                  state_in   = cht_pkg::S_CMP;
               end
            end else if (l_has) begin
               // length differs, follow the chain
               cur_in  = l_next;
               link_re = 1'b1;
               info_re = 1'b1;
            end else begin
               state_in = cht_pkg::S_DONE;
            end
         end

         cht_pkg::S_CMP: begin
            if (pair_rd_ff == pend_rd_ff) begin
               if (j_next == plen_ff) begin
                  res_hit_in = 1'b1;
                  state_in   = cht_pkg::S_DONE;
               end else begin
                  j_in    = j_next;
                  pair_re = 1'b1;
                  pend_re = 1'b1;
               end
            end else if (l_has) begin
               cur_in   = l_next;
               link_re  = 1'b1;
               info_re  = 1'b1;
               state_in = cht_pkg::S_ENT;
            end else begin
               state_in = cht_pkg::S_DONE;
            end
         end

         cht_pkg::S_INS_PAIR: begin
            pair_we = 1'b1;
            if (j_next == plen_ff) begin
               state_in = cht_pkg::S_INS_REC;
            end else begin
               j_in    = j_next;
               pend_re = 1'b1;
            end
         end

         cht_pkg::S_INS_REC: begin
            info_we   = 1'b1;
            link_we   = 1'b1;
            link_wdata = '0;
            bkt_we    = 1'b1;
            bkt_wdata = {1'b1, (b_valid ? b_head : cur_ff), cur_ff};
            used_in   = used_ff + 1'b1;
            state_in  = b_valid ? cht_pkg::S_INS_LINK : cht_pkg::S_DONE;
         end

         cht_pkg::S_INS_LINK: begin
            // old tail now points at the new entry
            link_we    = 1'b1;
            link_waddr = b_tail;
            link_wdata = {1'b1, cur_ff};
            state_in   = cht_pkg::S_DONE;
         end

         cht_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_full_in   = res_full_ff;
               rsp_long_in   = res_long_ff;
               rsp_status_in = res_hit_ff ? i_status : '0;
               rsp_move_in   = res_hit_ff ? i_move : cht_pkg::MOVE_NONE;
               rsp_loss_in   = res_hit_ff ? i_loss : '0;
               rsp_weight_in = res_hit_ff ? i_weight : '0;
               // the key is consumed
               plen_in  = '0;
               hash_in  = '0;
               ovf_in   = 1'b0;
               state_in = cht_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cht_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cht_pkg::S_CLEAR;
         clr_idx_ff   <= '0;
         used_ff      <= '0;
         plen_ff      <= '0;
         hash_ff      <= '0;
         ovf_ff       <= 1'b0;
         mult_ff      <= cht_pkg::HASH_MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         used_ff      <= used_in;
         plen_ff      <= plen_in;
         hash_ff      <= hash_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mult_ff <= csr_wr_data;
         end
      end
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      j_ff          <= j_in;
      dat_status_ff <= dat_status_in;
      dat_move_ff   <= dat_move_in;
      dat_loss_ff   <= dat_loss_in;
      dat_weight_ff <= dat_weight_in;
      res_hit_ff    <= res_hit_in;
      res_full_ff   <= res_full_in;
      res_long_ff   <= res_long_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_long_ff   <= rsp_long_in;
      rsp_status_ff <= rsp_status_in;
      rsp_move_ff   <= rsp_move_in;
      rsp_loss_ff   <= rsp_loss_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_pool_full    = rsp_full_ff;
   assign rsp_key_too_long = rsp_long_ff;
   assign rsp_found_status = rsp_status_ff;
   assign rsp_found_move   = rsp_move_ff;
   assign rsp_found_loss   = rsp_loss_ff;
   assign rsp_found_weight = rsp_weight_ff;

   // ---------------------------------------------------------------- checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX) else $error("pool use count past pool size");

   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LEN_MAX) else $error("pending key longer than max");

   a_hash_done: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == cht_pkg::S_HASH) else $error("hash done outside hash state");

   a_key_consumed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cht_pkg::S_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && plen_ff == '0 && !ovf_ff)) else $error("word not issued or key kept");

endmodule
